FILE: hw/rtl/ile_pkg.sv
// Shared types, widths and codes for the indexed list engine.
// No dependencies; used by ile_mem, ile_seq and indexed_list_engine.
package ile_pkg;

	// List depth and derived widths
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths of the item formats
	localparam int REQ_W   = 3;
	localparam int POS_W   = 7;
	localparam int WORD_W  = 32;
	localparam int STAT_W  = 3;
	localparam int FOUND_W = 6;
	localparam int ECNT_W  = 7;

	// Width used to compare a position against a count
	localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Stream data layouts (lowest field first, padded to whole bytes)
	localparam int IN_POS_LSB  = 0;
	localparam int IN_VAL_LSB  = IN_POS_LSB + POS_W;
	localparam int IN_KEY_LSB  = IN_VAL_LSB + WORD_W;
	localparam int IN_USED_W   = IN_KEY_LSB + WORD_W;
	localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
	localparam int OUT_FND_LSB = 0;
	localparam int OUT_RD_LSB  = OUT_FND_LSB + FOUND_W;
	localparam int OUT_CNT_LSB = OUT_RD_LSB + WORD_W;
	localparam int OUT_USED_W  = OUT_CNT_LSB + ECNT_W;
	localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WIDE_W-1:0] wide_t;
	typedef logic [WORD_W-1:0] word_t;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_POS  = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_MATCH = 3'd4;

	// Sequencer to storage: one write and one read port per cycle
	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		addr_t raddr;
	} mem_req_t;

	// Finished result of one item
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [FOUND_W-1:0] found_index;
		word_t              read_data;
		logic [ECNT_W-1:0]  entry_count;
	} result_t;

endpackage

FILE: hw/rtl/ile_mem.sv
// Entry storage of the list: one write port, one registered read port.
// Depends on ile_pkg.
module ile_mem (
	input  logic            clk,
	input  ile_pkg::mem_req_t req,
	output ile_pkg::word_t  rdata
);
	import ile_pkg::*;

	word_t store_q [CAPACITY];
	word_t rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			store_q[req.waddr] <= req.wdata;
		end
		rdata_q <= store_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/ile_seq.sv
// Request sequencer: bounds checks, then walks the storage one entry a cycle
// through a shared index stepper and word comparator. Depends on ile_pkg.
module ile_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ile_pkg::REQ_W-1:0]  req_type,
	input  logic [ile_pkg::POS_W-1:0]  position,
	input  ile_pkg::word_t             data_value,
	input  ile_pkg::word_t             search_key,
	output ile_pkg::mem_req_t          mem,
	input  ile_pkg::word_t             mem_rdata,
	output logic                       res_valid,
	input  logic                       res_ready,
	output ile_pkg::result_t           res
);
	import ile_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_INS    = 3'd2;
	localparam logic [2:0] S_DEL    = 3'd3;
	localparam logic [2:0] S_SRCH   = 3'd4;
	localparam logic [2:0] S_RD     = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [REQ_W-1:0]  req_q;
	logic [POS_W-1:0]  pos_q;
	word_t             val_q;
	word_t             key_q;
	cnt_t              count_q;
	cnt_t              idx_q;
	logic              pend_q;
	addr_t             wa_q;
	logic [STAT_W-1:0] status_q;
	addr_t             found_q;
	word_t             rdata_q;

	cnt_t  idx_nx;
	logic  hit;
	logic  ins_more;
	logic  del_more;
	logic  srch_more;
	wide_t pos_w;
	wide_t cnt_w;
	wide_t idx_w;

	// Shared stepper and comparator
	assign idx_nx    = idx_q + ((state_q == S_INS) ? {CNT_W{1'b1}} : CNT_W'(1));
	assign hit       = (mem_rdata == key_q);
	assign pos_w     = wide_t'(pos_q);
	assign cnt_w     = wide_t'(count_q);
	assign idx_w     = wide_t'(idx_q);
	assign ins_more  = (idx_w > pos_w);
	assign del_more  = (idx_nx < count_q);
	assign srch_more = (idx_q < count_q);

	// Storage port control
	always_comb begin
		mem       = '0;
		mem.raddr = addr_t'(idx_q);
		case (state_q)
			S_DECIDE: begin
				mem.raddr = addr_t'(pos_q);
				if (req_q == REQ_WRITE && count_q != '0 && pos_w < cnt_w) begin
					mem.we    = 1'b1;
					mem.waddr = addr_t'(pos_q);
					mem.wdata = val_q;
				end
			end
			S_INS: begin
				mem.raddr = addr_t'(idx_nx);
				if (pend_q) begin
					mem.we    = 1'b1;
					mem.waddr = wa_q;
					mem.wdata = mem_rdata;
				end else if (!ins_more) begin
					mem.we    = 1'b1;
					mem.waddr = addr_t'(pos_q);
					mem.wdata = val_q;
				end
			end
			S_DEL: begin
				mem.raddr = addr_t'(idx_nx);
				if (pend_q) begin
					mem.we    = 1'b1;
					mem.waddr = wa_q;
					mem.wdata = mem_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= '0;
			pos_q    <= '0;
			val_q    <= '0;
			key_q    <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			pend_q   <= 1'b0;
			wa_q     <= '0;
			status_q <= ST_OK;
			found_q  <= '0;
			rdata_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						pos_q   <= position;
						val_q   <= data_value;
						key_q   <= search_key;
						pend_q  <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					status_q <= ST_OK;
					found_q  <= '0;
					rdata_q  <= '0;
					state_q  <= S_DONE;
					case (req_q)
						REQ_INSERT: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
							end else if (pos_w > cnt_w) begin
								status_q <= ST_BAD_POS;
							end else begin
								idx_q   <= count_q;
								state_q <= S_INS;
							end
						end
						REQ_DELETE: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else if (pos_w >= cnt_w) begin
								status_q <= ST_BAD_POS;
							end else begin
								idx_q   <= CNT_W'(pos_q);
								state_q <= S_DEL;
							end
						end
						REQ_WRITE, REQ_READ: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else if (pos_w >= cnt_w) begin
								status_q <= ST_BAD_POS;
							end else if (req_q == REQ_READ) begin
								state_q <= S_RD;
							end
						end
						REQ_SEARCH: begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								idx_q   <= '0;
								state_q <= S_SRCH;
							end
						end
						default: begin
							status_q <= ST_BAD_POS;
						end
					endcase
				end
				// Move entries up, top down, then drop the new value in
				S_INS: begin
					if (ins_more) begin
						pend_q <= 1'b1;
						wa_q   <= addr_t'(idx_q);
						idx_q  <= idx_nx;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				// Move entries down from the deleted place
				S_DEL: begin
					if (del_more) begin
						pend_q <= 1'b1;
						wa_q   <= addr_t'(idx_q);
						idx_q  <= idx_nx;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				// Compare last read word, issue next read
				S_SRCH: begin
					if (pend_q && hit) begin
						found_q <= wa_q;
						state_q <= S_DONE;
					end else if (srch_more) begin
						pend_q <= 1'b1;
						wa_q   <= addr_t'(idx_q);
						idx_q  <= idx_nx;
					end else begin
						status_q <= ST_NO_MATCH;
						state_q  <= S_DONE;
					end
				end
				S_RD: begin
					rdata_q <= mem_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign res_valid       = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.found_index = FOUND_W'(found_q);
	assign res.read_data   = rdata_q;
	assign res.entry_count = ECNT_W'(count_q);

endmodule

FILE: hw/rtl/indexed_list_engine.sv
// Top level of the indexed list engine: stream ports, sequencer, storage
// and output register. Depends on ile_pkg, ile_mem and ile_seq.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | position, data_value, search_key, 1 pad     | req_type
//  m_      | out | found_index, read_data, entry_count, 3 pad  | status
//
// An item occupies the sequencer from acceptance until its result moves to
// the output register: rejects, overwrite and empty cases go from the decide
// state straight to done, read passes through a read state, insert and delete
// move the entries between the position and the count, and search walks the
// entries until a match or the count. Entries move one per cycle through the
// storage ports. Reset clears the count; entries are not cleared.
// s_tready is low while an item is in work; a stalled m_ side holds the
// result in the output register and the sequencer waits behind it.
module indexed_list_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ile_pkg::IN_DATA_W-1:0]    s_tdata,  // position, data_value, search_key
	input  logic [ile_pkg::REQ_W-1:0]        s_tuser,  // req_type
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ile_pkg::OUT_DATA_W-1:0]   m_tdata,  // found_index, read_data, entry_count
	output logic [ile_pkg::STAT_W-1:0]       m_tuser   // status
);
	import ile_pkg::*;

	mem_req_t mem;
	word_t    mem_rdata;
	logic     res_valid;
	logic     res_ready;
	result_t  res;
	logic     out_valid_q;
	result_t  out_q;

	ile_mem u_mem (
		.clk   (clk),
		.req   (mem),
		.rdata (mem_rdata)
	);

	ile_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.req_type   (s_tuser),
		.position   (s_tdata[IN_POS_LSB +: POS_W]),
		.data_value (s_tdata[IN_VAL_LSB +: WORD_W]),
		.search_key (s_tdata[IN_KEY_LSB +: WORD_W]),
		.mem        (mem),
		.mem_rdata  (mem_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = OUT_DATA_W'({out_q.entry_count, out_q.read_data, out_q.found_index});

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted again while an item is in work");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_q.entry_count <= ECNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.status == ST_FULL |-> out_q.entry_count == ECNT_W'(CAPACITY))
		else $error("full status with spare room");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.status != ST_OK |->
			out_q.found_index == '0 && out_q.read_data == '0)
		else $error("failed request carries index or data");

endmodule
